FILE: design/sto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session timeout queue package
// Shared types, widths and codes for the sorted deadline store and its cells.
// ----------------------------------------------------------------------------
package sto_pkg;

	localparam int SESSIONS   = 64;
	localparam int SESSION_W  = 6;
	localparam int DEADLINE_W = 32;
	localparam int OPCODE_W   = 2;
	localparam int STATUS_W   = 2;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_CHECK  = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0]          opcode;
		logic [SESSION_W-1:0]         session;
		logic signed [DEADLINE_W-1:0] deadline;
		logic signed [DEADLINE_W-1:0] now;
	} item_t;

	typedef struct packed {
		logic                 expired;
		logic [SESSION_W-1:0] expired_session;
		logic [STATUS_W-1:0]  status;
	} result_t;

	// One stored entry of the chain
	typedef struct packed {
		logic                         valid;
		logic signed [DEADLINE_W-1:0] deadline;
		logic [SESSION_W-1:0]         session;
	} entry_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic find;
		logic remove;
		logic insert;
	} cell_ctrl_t;

endpackage

FILE: design/sto_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session timeout queue cell
// One slot of the sorted chain: match flag, insert compare and neighbour shift.
// ----------------------------------------------------------------------------
module sto_cell
	import sto_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctrl_t                   ctrl,
	input  logic [SESSION_W-1:0]         key_session,
	input  logic signed [DEADLINE_W-1:0] key_deadline,
	input  entry_t                       prev_entry,
	input  logic                         prev_ge,
	input  entry_t                       next_entry,
	input  logic                         remove_here,
	output entry_t                       entry,
	output logic                         ge,
	output logic                         match_q
);

	logic                         valid_q;
	logic signed [DEADLINE_W-1:0] deadline_q;
	logic [SESSION_W-1:0]         session_q;
	entry_t                       nxt;
	logic                         load;

	assign entry = '{valid: valid_q, deadline: deadline_q, session: session_q};

	// new key goes at or before this slot
	assign ge = !valid_q || (key_deadline <= deadline_q);

	always_comb begin
		nxt  = entry;
		load = 1'b0;
		if (ctrl.remove && remove_here) begin
			// close the gap: take the right neighbour
			nxt  = next_entry;
			load = 1'b1;
		end else if (ctrl.insert) begin
			if (prev_ge) begin
				nxt  = prev_entry;
				load = 1'b1;
			end else if (ge) begin
				nxt  = '{valid: 1'b1, deadline: key_deadline, session: key_session};
				load = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= nxt.valid;
			end
			if (ctrl.find) begin
				match_q <= valid_q && (session_q == key_session);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			deadline_q <= nxt.deadline;
			session_q  <= nxt.session;
		end
	end

endmodule

FILE: design/session_timeout_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session timeout queue unit
// Sorted store of session deadlines, earliest first, built as a chain of cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while the chain works on it. A check item needs only the look-up; an
// insert, a remove or an update of a session that is not queued needs the
// look-up, then the shift of the chain or the status; and an update of a
// queued session needs look-up, remove shift and insert shift. The single
// result of each item is flagged by done for exactly one cycle, in the first
// cycle in which busy is low again. It cannot be held off, so the
// receiver must take it then; the next item may be offered in that same cycle.
// The sequence is set by the one shared look-up pass over all cells and the
// one shift of the chain per removal or insertion. After reset the queue is
// empty and the first item may be offered at once.
// ----------------------------------------------------------------------------
module session_timeout_queue_unit
	import sto_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int LVLS = $clog2(SESSIONS);

	// Sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_FIND   = 2'd1;
	localparam logic [1:0] S_APPLY  = 2'd2;
	localparam logic [1:0] S_INSERT = 2'd3;

	logic [1:0]    state_q;
	item_t         cmd_q;
	logic          done_q;
	result_t       result_q;

	cell_ctrl_t    ctrl;
	entry_t        entries [SESSIONS];
	logic [SESSIONS-1:0] ge;
	logic [SESSIONS-1:0] match_q;
	logic [SESSIONS-1:0] pre [LVLS+1];
	logic          found;
	logic          accept;
	logic [DEADLINE_W-1:0] diff;
	logic          due;
	logic          is_rm;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Prefix OR of the match flags: every cell at or after the matching one
	// closes up during a remove. Log-depth, one level per power of two.
	always_comb begin
		pre[0] = match_q;
		for (int l = 0; l < LVLS; l++) begin
			for (int i = 0; i < SESSIONS; i++) begin
				if (i >= (1 << l)) begin
					pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
				end else begin
					pre[l+1][i] = pre[l][i];
				end
			end
		end
	end

	assign found = pre[LVLS][SESSIONS-1];
	assign is_rm = (cmd_q.opcode == OP_REMOVE) || (cmd_q.opcode == OP_UPDATE);

	// Broadcast control: look up during FIND, shift in APPLY and INSERT
	always_comb begin
		ctrl.find   = (state_q == S_FIND);
		ctrl.remove = (state_q == S_APPLY) && is_rm && found;
		ctrl.insert = ((state_q == S_APPLY) && (cmd_q.opcode == OP_INSERT) && !found)
			|| (state_q == S_INSERT);
	end

	// Expiry test on the head cell: wrapped difference at most zero
	assign diff = entries[0].deadline - cmd_q.now;
	assign due  = entries[0].valid && ((diff == '0) || diff[DEADLINE_W-1]);

	// The chain
	for (genvar g = 0; g < SESSIONS; g++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_g;

		if (g == 0) begin : g_head
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = entries[g-1];
			assign prev_g = ge[g-1];
		end

		if (g == SESSIONS - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_body
			assign next_e = entries[g+1];
		end

		sto_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.key_session  (cmd_q.session),
			.key_deadline (cmd_q.deadline),
			.prev_entry   (prev_e),
			.prev_ge      (prev_g),
			.next_entry   (next_e),
			.remove_here  (pre[LVLS][g]),
			.entry        (entries[g]),
			.ge           (ge[g]),
			.match_q      (match_q[g])
		);
	end

	// Sequencer: hold the item, advance through the phases, drop a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (cmd_q.opcode == OP_CHECK) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if ((cmd_q.opcode == OP_UPDATE) && found) begin
						state_q <= S_INSERT;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_INSERT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: command capture and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item;
		end
		case (state_q)
			S_FIND: begin
				result_q.expired         <= due;
				result_q.expired_session <= due ? entries[0].session : '0;
				result_q.status          <= ST_OK;
			end
			S_APPLY: begin
				result_q.expired         <= 1'b0;
				result_q.expired_session <= '0;
				if ((cmd_q.opcode == OP_INSERT) && found) begin
					result_q.status <= ST_DUPLICATE;
				end else if (is_rm && !found) begin
					result_q.status <= ST_ABSENT;
				end else begin
					result_q.status <= ST_OK;
				end
			end
			S_INSERT: begin
				result_q.expired         <= 1'b0;
				result_q.expired_session <= '0;
				result_q.status          <= ST_OK;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

endmodule

FILE: bench/sto_bench_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session deadline scoreboard
// Predicts the sorted deadline store and checks each result against it.
// ----------------------------------------------------------------------------
package sto_bench_pkg;

	import sto_pkg::*;

	class deadline_order_board;
		entry_t  cells[SESSIONS];
		result_t due_results[$];
		int      mismatches;
		int      items_noted;
		int      results_seen;
		int      dup_count;
		int      absent_count;
		int      expiry_count;
		int      peak_fill;

		function new();
			foreach (cells[i]) cells[i] = '0;
			mismatches   = 0;
			items_noted  = 0;
			results_seen = 0;
			dup_count    = 0;
			absent_count = 0;
			expiry_count = 0;
			peak_fill    = 0;
		endfunction

		function int fill();
			int n;
			n = 0;
			foreach (cells[i]) if (cells[i].valid) n++;
			return n;
		endfunction

		function int locate(logic [SESSION_W-1:0] s);
			foreach (cells[i]) if (cells[i].valid && cells[i].session == s) return i;
			return -1;
		endfunction

		function void drop_at(int p);
			for (int i = p; i < SESSIONS - 1; i++) cells[i] = cells[i + 1];
			cells[SESSIONS - 1] = '0;
		endfunction

		// newest goes in front of equal deadlines
		function void place_sorted(logic [SESSION_W-1:0] s, logic signed [DEADLINE_W-1:0] dl);
			int p;
			p = 0;
			while (p < SESSIONS && cells[p].valid && dl > $signed(cells[p].deadline)) p++;
			if (p >= SESSIONS) return;
			for (int i = SESSIONS - 1; i > p; i--) cells[i] = cells[i - 1];
			cells[p].valid    = 1'b1;
			cells[p].deadline = dl;
			cells[p].session  = s;
		endfunction

		function void note_item(item_t it);
			result_t                 r;
			int                      p;
			logic [DEADLINE_W-1:0]   diff;
			r = '0;
			case (it.opcode)
				OP_INSERT: begin
					if (locate(it.session) >= 0) r.status = ST_DUPLICATE;
					else place_sorted(it.session, it.deadline);
				end
				OP_REMOVE, OP_UPDATE: begin
					p = locate(it.session);
					if (p < 0) begin
						r.status = ST_ABSENT;
					end else begin
						drop_at(p);
						if (it.opcode == OP_UPDATE) place_sorted(it.session, it.deadline);
					end
				end
				OP_CHECK: begin
					if (cells[0].valid) begin
						diff = cells[0].deadline - it.now;
						if (diff == '0 || diff[DEADLINE_W-1]) begin
							r.expired         = 1'b1;
							r.expired_session = cells[0].session;
						end
					end
				end
				default: ;
			endcase
			if (r.status == ST_DUPLICATE) dup_count++;
			if (r.status == ST_ABSENT) absent_count++;
			if (r.expired) expiry_count++;
			if (fill() > peak_fill) peak_fill = fill();
			items_noted++;
			due_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result expired=%0b session=%0d status=%0d",
						$time, got.expired, got.expired_session, got.status);
				return;
			end
			want = due_results.pop_front();
			if (got.expired !== want.expired || got.expired_session !== want.expired_session ||
					got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch expected expired=%0b session=%0d status=%0d, got expired=%0b session=%0d status=%0d",
						$time, want.expired, want.expired_session, want.status,
						got.expired, got.expired_session, got.status);
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// valid cells form a prefix, so any index below the fill is queued
		function logic [SESSION_W-1:0] pick_queued();
			int n;
			n = fill();
			if (n == 0) return SESSION_W'($urandom_range(0, SESSIONS - 1));
			return cells[$urandom_range(0, n - 1)].session;
		endfunction

		function logic [SESSION_W-1:0] pick_absent();
			logic [SESSION_W-1:0] s;
			s = SESSION_W'($urandom_range(0, SESSIONS - 1));
			for (int k = 0; k < 200 && locate(s) >= 0; k++)
				s = SESSION_W'($urandom_range(0, SESSIONS - 1));
			return s;
		endfunction
	endclass

endpackage

FILE: bench/tb_session_timeout_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session timeout queue unit testbench
// Drives insert, remove, update and expiry-check items through the command
// handshake with random gaps, predicts every result from a model of the sorted
// store and checks each one as it appears on the strobe.
// ----------------------------------------------------------------------------
module tb_session_timeout_queue_unit;

	import sto_pkg::*;
	import sto_bench_pkg::*;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	deadline_order_board board = new();

	// Time base around which random deadlines and check times cluster
	int base;
	// Set for a phase that runs with no idle cycles at all
	bit quiet;

	session_timeout_queue_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Results cannot be held off: take every strobed one at the edge ending it
	always @(posedge clk) begin
		if (arst_n && done) board.check_result(result);
	end

	// Hold start and the item until the block takes it, then note it for the
	// predictor. Called at a rising edge; returns at the edge of acceptance.
	task automatic offer(input item_t it);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		board.note_item(it);
	endtask

	// Drop start for a random gap: mostly none or short, now and then long
	task automatic idle_gap();
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50) gap = 0;
		else if (roll < 90) gap = $urandom_range(1, 3);
		else if (roll < 98) gap = $urandom_range(4, 10);
		else gap = $urandom_range(20, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic item_t make_item(logic [OPCODE_W-1:0] op, int s, int dl, int t);
		item_t it;
		it.opcode   = op;
		it.session  = SESSION_W'(s);
		it.deadline = dl;
		it.now      = t;
		return it;
	endfunction

	task automatic send(input item_t it);
		offer(it);
		idle_gap();
	endtask

	// Walk the corners: empty queue, absent sessions, signed extremes of the
	// deadline, ties, duplicates, wrapped expiry distance and a full drain.
	task automatic run_directed();
		send(make_item(OP_CHECK,  0,  0, 0));
		send(make_item(OP_REMOVE, 5,  0, 0));
		send(make_item(OP_UPDATE, 7,  9, 0));
		send(make_item(OP_INSERT, 0,  32'h7FFF_FFFF, 0));
		send(make_item(OP_INSERT, 63, 32'h8000_0000, 0));
		send(make_item(OP_INSERT, 10, 100, 0));
		// equal deadline: the newer entry must sit in front
		send(make_item(OP_INSERT, 11, 100, 0));
		send(make_item(OP_INSERT, 10, 5, 0));
		// the earliest is most negative; one step short of due across the wrap
		send(make_item(OP_CHECK,  0,  0, 32'h7FFF_FFFF));
		send(make_item(OP_CHECK,  0,  0, 32'h8000_0000));
		send(make_item(OP_CHECK,  0,  0, 32'h8000_0001));
		send(make_item(OP_REMOVE, 63, 0, 0));
		send(make_item(OP_CHECK,  0,  0, 100));
		send(make_item(OP_CHECK,  0,  0, 99));
		// reinsert moves session 10 ahead of 11 on the same deadline
		send(make_item(OP_UPDATE, 10, 100, 0));
		send(make_item(OP_CHECK,  0,  0, 200));
		send(make_item(OP_UPDATE, 0,  -5, 0));
		send(make_item(OP_CHECK,  0,  0, -5));
		send(make_item(OP_REMOVE, 11, 0, 0));
		send(make_item(OP_REMOVE, 10, 0, 0));
		send(make_item(OP_REMOVE, 0,  0, 0));
		send(make_item(OP_REMOVE, 0,  0, 0));
		send(make_item(OP_CHECK,  63, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
	endtask

	// One random item, steered towards a target fill so that the queue both
	// empties and fills up over the run
	function automatic item_t draw_item(int target);
		item_t it;
		int    roll;
		int    pick;
		roll = $urandom_range(0, 99);
		if (roll < 15) it.opcode = OP_CHECK;
		else if (board.fill() < target)
			it.opcode = (roll < 70) ? OP_INSERT : ((roll < 85) ? OP_UPDATE : OP_REMOVE);
		else
			it.opcode = (roll < 35) ? OP_INSERT : ((roll < 70) ? OP_REMOVE : OP_UPDATE);

		pick = $urandom_range(0, 99);
		if (it.opcode == OP_INSERT)
			it.session = (pick < 80) ? board.pick_absent() : board.pick_queued();
		else if (it.opcode == OP_CHECK)
			it.session = SESSION_W'($urandom_range(0, SESSIONS - 1));
		else
			it.session = (pick < 80) ? board.pick_queued() : board.pick_absent();

		// narrow window for ties, wider spread, or any value at all
		pick = $urandom_range(0, 99);
		if (pick < 70) it.deadline = base + int'($urandom_range(0, 20)) - 10;
		else if (pick < 90) it.deadline = base + int'($urandom_range(0, 200000)) - 100000;
		else it.deadline = $urandom;

		pick = $urandom_range(0, 99);
		if (pick < 85) it.now = base + int'($urandom_range(0, 30)) - 15;
		else it.now = $urandom;

		// advance the clock of the sessions slowly
		base += int'($urandom_range(0, 3));
		return it;
	endfunction

	task automatic run_random(input int count);
		int target;
		for (int n = 0; n < count; n++) begin
			// new phase: fresh fill target, idling style and time base
			if (n % 100 == 0) begin
				target = $urandom_range(0, SESSIONS);
				quiet  = ($urandom_range(0, 3) == 0);
				// half the phases straddle the signed wrap of the deadline
				if ($urandom_range(0, 1)) base = 32'h7FFF_FFC0 + int'($urandom_range(0, 40));
				else base = $urandom;
			end
			send(draw_item(target));
		end
	endtask

	initial begin
		int spins;
		quiet = 1'b0;
		base  = 0;
		// hold reset, then release it at a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(1100);
		start <= 1'b0;

		// drain what is still in flight, then let the block settle
		spins = 0;
		while (board.pending() != 0 && spins < 2000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);

		$display("Ran %0d items, checked %0d results; peak fill %0d of %0d sessions.",
			board.items_noted, board.results_seen, board.peak_fill, SESSIONS);
		$display("Seen %0d expiries, %0d duplicate inserts, %0d absent removes or updates.",
			board.expiry_count, board.dup_count, board.absent_count);
		if (board.pending() != 0)
			$display("%0d expected results never arrived", board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches in total", board.mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Timeout waiting on the block");
		$display("Test completed with failures");
		$finish;
	end

endmodule
